FILE: rtl/rsd_pkg.sv
package rsd_pkg;

   localparam int SAMPLE_WIDTH = 64;
   localparam int STEP_COUNT_WIDTH = 6;
   localparam int TYPE_WIDTH = 3;
   localparam int SHORT_RUN_MAX = 3;
   localparam logic [TYPE_WIDTH-1:0] DATA_TYPE_RESET = 3'd2;

   localparam logic [1:0] WIDTH_8 = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;
   localparam logic [1:0] WIDTH_64 = 2'd3;

   typedef enum logic [1:0] {
      STATUS_REGULAR = 2'd0,
      STATUS_SHORT = 2'd1,
      STATUS_IRREGULAR = 2'd2
   } status_type;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] sample_value;
      logic last_sample;
   } req_word_type;

   typedef struct packed {
      status_type status;
      logic [SAMPLE_WIDTH-1:0] start_value;
      logic [SAMPLE_WIDTH-1:0] step_value;
   } rsp_word_type;

   typedef struct packed {
      logic accept;
      logic start_div;
      logic load_direct;
      logic load_div;
   } rsd_cmd_type;

   typedef struct packed {
      logic last;
      logic regular;
      logic div_done;
   } rsd_stat_type;

   function automatic logic [SAMPLE_WIDTH-1:0] type_mask(input logic [1:0] wsel);
      logic [SAMPLE_WIDTH-1:0] mask;
      unique case (wsel)
         WIDTH_8: mask = 64'h0000_0000_0000_00ff;
         WIDTH_16: mask = 64'h0000_0000_0000_ffff;
         WIDTH_32: mask = 64'h0000_0000_ffff_ffff;
         default: mask = 64'hffff_ffff_ffff_ffff;
      endcase
      return mask;
   endfunction

   function automatic logic sign_bit(input logic [1:0] wsel,
                                     input logic [SAMPLE_WIDTH-1:0] value);
      logic bit_out;
      unique case (wsel)
         WIDTH_8: bit_out = value[7];
         WIDTH_16: bit_out = value[15];
         WIDTH_32: bit_out = value[31];
         default: bit_out = value[63];
      endcase
      return bit_out;
   endfunction

endpackage

FILE: rtl/regular_spacing_detector.sv
// Checks whether a run of integer samples is evenly spaced. Each req word carries
// one sample; the word with last_sample set closes the run and yields one rsp word
// with the first value and the step, or a code for a run of three or fewer samples
// or for irregular spacing. Samples and steps wrap at the width chosen by the
// data type register (csr port, always ready, reset int32). Every non-final
// sample is taken while no divide is under way, as is the final sample of a
// short or irregular run. The final sample of a regular run is taken at once
// but then blocks the input until the step is in the result register: the
// step comes from a bit-serial divider, started in the accepting cycle, that
// works through the 64-bit span; its quotient then goes to the result
// register. A final sample is also held while an earlier result still
// waits in the result register.
module regular_spacing_detector #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [rsd_pkg::TYPE_WIDTH-1:0] csr_wdata,
   input  logic req_valid,
   output logic req_ready,
   input  rsd_pkg::req_word_type req_word,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsd_pkg::rsp_word_type rsp_word
);
   import rsd_pkg::*;

   rsd_cmd_type cmd;
   rsd_stat_type stat;

   rsd_controller u_controller (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .stat(stat),
      .cmd(cmd)
   );

   rsd_datapath #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata),
      .req_word(req_word),
      .rsp_word(rsp_word),
      .cmd(cmd),
      .stat(stat)
   );

endmodule

FILE: rtl/rsd_divider.sv
module rsd_divider #(
   parameter int DIVISOR_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [rsd_pkg::SAMPLE_WIDTH-1:0] dividend,
   input  logic [DIVISOR_WIDTH-1:0] divisor,
   output logic done,
   output logic [rsd_pkg::SAMPLE_WIDTH-1:0] quotient
);
   import rsd_pkg::*;

   localparam logic [STEP_COUNT_WIDTH-1:0] LastStep = STEP_COUNT_WIDTH'(SAMPLE_WIDTH - 1);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [STEP_COUNT_WIDTH-1:0] step_ff, step_in;
   logic [DIVISOR_WIDTH-1:0] rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0] divisor_ff, divisor_in;
   logic [SAMPLE_WIDTH-1:0] quot_ff, quot_in;
   logic [DIVISOR_WIDTH:0] shifted;
   logic [DIVISOR_WIDTH:0] trial;
   logic fits;

   assign shifted = {rem_ff, quot_ff[SAMPLE_WIDTH-1]};
   assign trial = shifted - {1'b0, divisor_ff};
   assign fits = ~trial[DIVISOR_WIDTH];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in = '0;
         divisor_in = divisor;
         quot_in = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DIVISOR_WIDTH-1:0] : shifted[DIVISOR_WIDTH-1:0];
         quot_in = {quot_ff[SAMPLE_WIDTH-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quotient = quot_ff;

endmodule

FILE: rtl/rsd_datapath.sv
module rsd_datapath #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [rsd_pkg::TYPE_WIDTH-1:0] csr_wdata,
   input  rsd_pkg::req_word_type req_word,
   output rsd_pkg::rsp_word_type rsp_word,
   input  rsd_pkg::rsd_cmd_type cmd,
   output rsd_pkg::rsd_stat_type stat
);
   import rsd_pkg::*;

   logic [TYPE_WIDTH-1:0] data_type_ff;
   logic [SAMPLE_WIDTH-1:0] first_ff, prev_ff, pstep_ff;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic irregular_ff, irregular_in;
   logic neg_ff;
   logic [SAMPLE_WIDTH-1:0] mask_ff, start_ff;
   rsp_word_type rsp_word_ff;

   logic [SAMPLE_WIDTH-1:0] mask, sample, delta, span, extended, magnitude;
   logic [SAMPLE_WIDTH-1:0] signed_quot;
   logic [SAMPLE_WIDTH-1:0] quotient;
   logic [COUNT_WIDTH-1:0] divisor;
   logic negative, div_done;
   status_type final_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_type_ff <= DATA_TYPE_RESET;
      end else if (csr_valid) begin
         data_type_ff <= csr_wdata;
      end
   end

   assign mask = type_mask(data_type_ff[1:0]);
   assign sample = req_word.sample_value & mask;
   assign delta = (sample - (prev_ff & mask)) & mask;
   assign span = (sample - (first_ff & mask)) & mask;

   always_comb begin
      count_in = (count_ff != '1) ? count_ff + 1'b1 : count_ff;
      irregular_in = irregular_ff;
      if ((count_ff > COUNT_WIDTH'(1)) && (delta != (pstep_ff & mask))) begin
         irregular_in = 1'b1;
      end
      if (count_in <= COUNT_WIDTH'(SHORT_RUN_MAX)) begin
         final_status = STATUS_SHORT;
      end else if (irregular_in) begin
         final_status = STATUS_IRREGULAR;
      end else begin
         final_status = STATUS_REGULAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         irregular_ff <= 1'b0;
      end else if (cmd.accept) begin
         count_ff <= req_word.last_sample ? '0 : count_in;
         irregular_ff <= req_word.last_sample ? 1'b0 : irregular_in;
      end
      if (cmd.accept) begin
         if (count_ff == '0) begin
            first_ff <= sample;
         end else begin
            pstep_ff <= delta;
         end
         prev_ff <= sample;
      end
   end

   // signed runs divide the magnitude and restore the sign afterwards
   assign negative = ~data_type_ff[2] & sign_bit(data_type_ff[1:0], span);
   assign extended = negative ? (span | ~mask) : span;
   assign magnitude = negative ? (SAMPLE_WIDTH'(0) - extended) : extended;
   assign divisor = count_in - 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.start_div) begin
         neg_ff <= negative;
         mask_ff <= mask;
         start_ff <= first_ff & mask;
      end
   end

   rsd_divider #(
      .DIVISOR_WIDTH(COUNT_WIDTH)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .start(cmd.start_div),
      .dividend(magnitude),
      .divisor(divisor),
      .done(div_done),
      .quotient(quotient)
   );

   assign signed_quot = neg_ff ? (SAMPLE_WIDTH'(0) - quotient) : quotient;

   always_ff @(posedge clock) begin
      if (cmd.load_direct) begin
         rsp_word_ff.status <= final_status;
         rsp_word_ff.start_value <= '0;
         rsp_word_ff.step_value <= '0;
      end else if (cmd.load_div) begin
         rsp_word_ff.status <= STATUS_REGULAR;
         rsp_word_ff.start_value <= start_ff;
         rsp_word_ff.step_value <= signed_quot & mask_ff;
      end
   end

   assign rsp_word = rsp_word_ff;
   assign stat.last = req_word.last_sample;
   assign stat.regular = (final_status == STATUS_REGULAR);
   assign stat.div_done = div_done;

endmodule

FILE: rtl/rsd_controller.sv
module rsd_controller (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  rsd_pkg::rsd_stat_type stat,
   output rsd_pkg::rsd_cmd_type cmd
);
   import rsd_pkg::*;

   typedef enum logic {
      STATE_IDLE,
      STATE_DIVIDE
   } state_type;

   state_type state_ff;
   logic rsp_valid_ff;

   // a final word waits until the result register is free
   assign req_ready = (state_ff == STATE_IDLE) && !(stat.last && rsp_valid_ff);

   always_comb begin
      cmd.accept = req_valid && req_ready;
      cmd.start_div = cmd.accept && stat.last && stat.regular;
      cmd.load_direct = cmd.accept && stat.last && !stat.regular;
      cmd.load_div = (state_ff == STATE_DIVIDE) && stat.div_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_direct || cmd.load_div) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            STATE_IDLE: begin
               if (cmd.start_div) begin
                  state_ff <= STATE_DIVIDE;
               end
            end
            STATE_DIVIDE: begin
               if (stat.div_done) begin
                  state_ff <= STATE_IDLE;
               end
            end
            default: state_ff <= STATE_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_start_enters_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.start_div |=> (state_ff == STATE_DIVIDE))
      else $error("divide not entered after start");

   a_div_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_div |-> !rsp_valid_ff)
      else $error("divide result overwrites unread word");

   a_direct_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_direct |-> !rsp_valid_ff)
      else $error("status result overwrites unread word");

   a_done_only_dividing: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> (state_ff == STATE_DIVIDE))
      else $error("divider done outside divide state");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import rsd_pkg::*;

   localparam int CNT_WIDTH = 32;
   localparam int RANDOM_ITEMS = 1100;
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT = 500000;

   localparam logic [TYPE_WIDTH-1:0] DT_INT8 = 3'd0;
   localparam logic [TYPE_WIDTH-1:0] DT_INT16 = 3'd1;
   localparam logic [TYPE_WIDTH-1:0] DT_INT32 = 3'd2;
   localparam logic [TYPE_WIDTH-1:0] DT_INT64 = 3'd3;
   localparam logic [TYPE_WIDTH-1:0] DT_UINT8 = 3'd4;
   localparam logic [TYPE_WIDTH-1:0] DT_UINT16 = 3'd5;
   localparam logic [TYPE_WIDTH-1:0] DT_UINT32 = 3'd6;
   localparam logic [TYPE_WIDTH-1:0] DT_UINT64 = 3'd7;

   typedef enum logic {ROW_CONFIG, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [SAMPLE_WIDTH-1:0] value;
      logic last;
      logic typed;
      rsp_word_type answer;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [TYPE_WIDTH-1:0] csr_wdata = DATA_TYPE_RESET;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   // spacing predictor state
   logic [TYPE_WIDTH-1:0] cur_type = DATA_TYPE_RESET;
   logic [SAMPLE_WIDTH-1:0] run_first = '0;
   logic [SAMPLE_WIDTH-1:0] run_prev = '0;
   logic [SAMPLE_WIDTH-1:0] run_stride = '0;
   logic [CNT_WIDTH-1:0] run_count = '0;
   logic run_irregular = 1'b0;

   rsp_word_type expected_results[$];
   stim_row_type directed_rows[$];
   int error_count = 0;
   int random_items = 0;
   int phase_items = 0;
   int burst_left = 0;
   logic [TYPE_WIDTH-1:0] phase_type = DATA_TYPE_RESET;
   logic row_typed = 1'b0;
   rsp_word_type row_answer = '0;
   logic [31:0] ready_tick = '0;
   logic [15:0] stall_pattern = 16'hffff;

   regular_spacing_detector #(
      .COUNT_WIDTH(CNT_WIDTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [SAMPLE_WIDTH-1:0] width_mask(input logic [TYPE_WIDTH-1:0] dt);
      case (dt[1:0])
         WIDTH_8: return 64'h0000_0000_0000_00ff;
         WIDTH_16: return 64'h0000_0000_0000_ffff;
         WIDTH_32: return 64'h0000_0000_ffff_ffff;
         default: return 64'hffff_ffff_ffff_ffff;
      endcase
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] mean_stride(input logic [SAMPLE_WIDTH-1:0] span,
                                                           input logic [CNT_WIDTH-1:0] count,
                                                           input logic [TYPE_WIDTH-1:0] dt);
      logic [SAMPLE_WIDTH-1:0] mask, sign, ext, mag, quot, divisor;
      logic neg;
      mask = width_mask(dt);
      divisor = 64'(count) - 64'd1;
      if (!dt[2]) begin
         sign = mask ^ (mask >> 1);
         neg = |(span & sign);
         ext = neg ? (span | ~mask) : span;
         mag = neg ? (64'd0 - ext) : ext;
         quot = mag / divisor;
         if (neg) quot = 64'd0 - quot;
      end else begin
         quot = span / divisor;
      end
      return quot & mask;
   endfunction

   function automatic logic predict_word(input req_word_type w, output rsp_word_type r);
      logic [SAMPLE_WIDTH-1:0] mask, x, d;
      mask = width_mask(cur_type);
      x = w.sample_value & mask;
      r = '0;
      if (run_count == 0) begin
         run_first = x;
      end else begin
         d = (x - (run_prev & mask)) & mask;
         if (run_count >= 2 && d != (run_stride & mask)) run_irregular = 1'b1;
         run_stride = d;
      end
      run_prev = x;
      if (run_count != '1) run_count = run_count + 1'b1;
      if (!w.last_sample) return 1'b0;
      if (run_count <= CNT_WIDTH'(SHORT_RUN_MAX)) begin
         r.status = STATUS_SHORT;
      end else if (run_irregular) begin
         r.status = STATUS_IRREGULAR;
      end else begin
         r.status = STATUS_REGULAR;
         r.start_value = run_first & mask;
         r.step_value = mean_stride((x - (run_first & mask)) & mask, run_count, cur_type);
      end
      run_first = '0;
      run_prev = '0;
      run_stride = '0;
      run_count = '0;
      run_irregular = 1'b0;
      return 1'b1;
   endfunction

   function automatic stim_row_type config_row(input logic [TYPE_WIDTH-1:0] dt);
      stim_row_type row;
      row.kind = ROW_CONFIG;
      row.value = 64'(dt);
      row.last = 1'b0;
      row.typed = 1'b0;
      row.answer = '0;
      return row;
   endfunction

   function automatic stim_row_type sample_row(input logic [SAMPLE_WIDTH-1:0] value,
                                               input logic last);
      stim_row_type row;
      row.kind = ROW_SAMPLE;
      row.value = value;
      row.last = last;
      row.typed = 1'b0;
      row.answer = '0;
      return row;
   endfunction

   function automatic stim_row_type answer_row(input logic [SAMPLE_WIDTH-1:0] value,
                                               input status_type st,
                                               input logic [SAMPLE_WIDTH-1:0] start,
                                               input logic [SAMPLE_WIDTH-1:0] stride);
      stim_row_type row;
      row = sample_row(value, 1'b1);
      row.typed = 1'b1;
      row.answer.status = st;
      row.answer.start_value = start;
      row.answer.step_value = stride;
      return row;
   endfunction

   task automatic compare_field(input string name, input logic [SAMPLE_WIDTH-1:0] want,
                                input logic [SAMPLE_WIDTH-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // monitor: predict on accepted req words, check accepted rsp words
   always @(posedge clock) begin : monitor
      rsp_word_type predicted;
      rsp_word_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) cur_type = csr_wdata;
         if (req_valid && req_ready) begin
            if (predict_word(req_word, predicted))
               expected_results.push_back(row_typed ? row_answer : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected word, expected none actual status %0d start %h step %h",
                        $time, rsp_word.status, rsp_word.start_value, rsp_word.step_value);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("status", 64'(want.status), 64'(rsp_word.status));
               compare_field("start_value", want.start_value, rsp_word.start_value);
               compare_field("step_value", want.step_value, rsp_word.step_value);
            end
         end
      end
   end

   always @(negedge clock) begin : receiver
      ready_tick = ready_tick + 1;
      if (ready_tick[5:0] == 6'd0) begin
         case ($urandom_range(0, 3))
            0: stall_pattern = 16'hffff;
            1: stall_pattern = 16'($urandom);
            2: stall_pattern = 16'($urandom & $urandom);
            default: stall_pattern = 16'h0001;
         endcase
         stall_pattern[0] = 1'b1;
      end
      rsp_ready <= stall_pattern[ready_tick[3:0]];
   end

   task automatic send_word(input logic [SAMPLE_WIDTH-1:0] value, input logic last,
                            input logic typed, input rsp_word_type answer);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      row_typed = typed;
      row_answer = answer;
      req_word <= '{sample_value: value, last_sample: last};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_data_type(input logic [TYPE_WIDTH-1:0] dt);
      csr_wdata <= dt;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_run();
      int len, kind, bad_at;
      logic [SAMPLE_WIDTH-1:0] mask, start, stride, value;
      mask = width_mask(phase_type);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      kind = $urandom_range(0, 19);
      start = rand64();
      case ($urandom_range(0, 4))
         0: stride = 64'd0;
         1: stride = 64'($urandom_range(1, 5));
         2: stride = 64'd0 - 64'($urandom_range(1, 5));
         3: stride = rand64();
         default: stride = 64'd1 << $urandom_range(0, 63);
      endcase
      bad_at = $urandom_range(1, (len > 1) ? len - 1 : 1);
      for (int k = 0; k < len; k++) begin
         value = start + stride * 64'(k);
         if (kind >= 17) value = rand64();
         else if (kind >= 14 && k == bad_at) value = value + 64'($urandom_range(1, 100));
         value = (value & mask) | (rand64() & ~mask);
         send_word(value, k == len - 1, 1'b0, '0);
      end
      random_items += len;
      phase_items += len;
   endtask

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      int phase, phase_goal;
      // reset type int32
      directed_rows.push_back(answer_row(64'd5, STATUS_SHORT, 64'd0, 64'd0));
      directed_rows.push_back(sample_row(64'd10, 1'b0));
      directed_rows.push_back(sample_row(64'd20, 1'b0));
      directed_rows.push_back(sample_row(64'd30, 1'b0));
      directed_rows.push_back(answer_row(64'd40, STATUS_REGULAR, 64'd10, 64'd10));
      directed_rows.push_back(sample_row(64'd0, 1'b0));
      directed_rows.push_back(sample_row(64'd1, 1'b0));
      directed_rows.push_back(sample_row(64'd3, 1'b0));
      directed_rows.push_back(answer_row(64'd4, STATUS_IRREGULAR, 64'd0, 64'd0));
      // three samples, irregular too
      directed_rows.push_back(sample_row(64'd0, 1'b0));
      directed_rows.push_back(sample_row(64'd1, 1'b0));
      directed_rows.push_back(answer_row(64'd5, STATUS_SHORT, 64'd0, 64'd0));
      // wrap through zero
      directed_rows.push_back(config_row(DT_UINT64));
      directed_rows.push_back(sample_row(64'hffff_ffff_ffff_ffff, 1'b0));
      directed_rows.push_back(sample_row(64'd0, 1'b0));
      directed_rows.push_back(sample_row(64'd1, 1'b0));
      directed_rows.push_back(answer_row(64'd2, STATUS_REGULAR, 64'hffff_ffff_ffff_ffff, 64'd1));
      // overflowing step, signed then unsigned, garbage in upper bits
      directed_rows.push_back(config_row(DT_INT8));
      directed_rows.push_back(sample_row(64'hffff_ffff_ffff_ff00, 1'b0));
      directed_rows.push_back(sample_row(64'h1234_5678_9abc_de50, 1'b0));
      directed_rows.push_back(sample_row(64'h0000_0000_0000_00a0, 1'b0));
      directed_rows.push_back(sample_row(64'h8000_0000_0000_00f0, 1'b1));
      directed_rows.push_back(config_row(DT_UINT8));
      directed_rows.push_back(sample_row(64'hffff_ffff_ffff_ff00, 1'b0));
      directed_rows.push_back(sample_row(64'h1234_5678_9abc_de50, 1'b0));
      directed_rows.push_back(sample_row(64'h0000_0000_0000_00a0, 1'b0));
      directed_rows.push_back(sample_row(64'h8000_0000_0000_00f0, 1'b1));
      // type change inside a run
      directed_rows.push_back(config_row(DT_INT16));
      directed_rows.push_back(sample_row(64'd100, 1'b0));
      directed_rows.push_back(sample_row(64'd200, 1'b0));
      directed_rows.push_back(config_row(DT_INT64));
      directed_rows.push_back(sample_row(64'd300, 1'b0));
      directed_rows.push_back(sample_row(64'd400, 1'b1));

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CONFIG) begin
            settle_block();
            write_data_type(directed_rows[i].value[TYPE_WIDTH-1:0]);
            phase_type = directed_rows[i].value[TYPE_WIDTH-1:0];
         end else begin
            send_word(directed_rows[i].value, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].answer);
         end
      end

      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         settle_block();
         phase_type = (phase < 8) ? phase[TYPE_WIDTH-1:0] : TYPE_WIDTH'($urandom_range(0, 7));
         write_data_type(phase_type);
         phase_goal = $urandom_range(60, 140);
         phase_items = 0;
         while (phase_items < phase_goal && random_items < RANDOM_ITEMS) send_run();
         phase++;
      end

      settle_block();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
